// File: rtl/jss_pkg.sv
// Shared types and constants of the Jacobi stencil sweep unit.
// Used by every module of the block but jss_ram; depends on nothing else.
package jss_pkg;

  localparam int VALUE_BITS     = 32;
  localparam int LINE_MAX       = 4096;
  localparam int COL_BITS       = $clog2(LINE_MAX);
  localparam int ROW_BITS       = 16;
  localparam int COLS_CFG_BITS  = 13;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam int SUM_BITS       = VALUE_BITS + 2;
  localparam int LINE_BITS      = 2 * VALUE_BITS;
  localparam int FIFO_DEPTH     = 8;
  localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS  = FIFO_PTR_BITS + 1;
  localparam int OCC_BITS       = FIFO_CNT_BITS + 1;

  localparam logic [ROW_BITS-1:0]      ROWS_MIN    = ROW_BITS'(3);
  localparam logic [COLS_CFG_BITS-1:0] COLS_MIN    = COLS_CFG_BITS'(3);
  localparam logic [COLS_CFG_BITS-1:0] COLS_MAX    = COLS_CFG_BITS'(LINE_MAX);
  localparam logic [ROW_BITS-1:0]      ROWS_RESET  = ROW_BITS'(3);
  localparam logic [COLS_CFG_BITS-1:0] COLS_RESET  = COLS_CFG_BITS'(3);
  localparam logic [VALUE_BITS-1:0]    THRESH_RESET = VALUE_BITS'(1);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_GRID_ROWS   = 2'd0,
    REG_GRID_COLS   = 2'd1,
    REG_CONV_THRESH = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] cell_value;
    logic                  sweep_start;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] new_value;
    logic [ROW_BITS-1:0]   out_row;
    logic [COL_BITS-1:0]   out_col;
    logic [VALUE_BITS-1:0] cell_change;
    logic [VALUE_BITS-1:0] sweep_max_change;
    logic                  converged;
    logic                  sweep_done;
  } out_word_t;

  // Position of one word in the raster and what it triggers.
  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                emit;  // completes an interior cell
    logic                done;  // completes the last interior cell
    logic                clr;   // sweep start: maximum clears before this word
    logic                endg;  // last word of the grid: maximum clears after it
  } pos_t;

  typedef struct packed {
    logic                  valid;
    pos_t                  pos;
    logic [VALUE_BITS-1:0] nv;
    logic [VALUE_BITS-1:0] centre;
  } stencil_t;

  typedef struct packed {
    logic                  valid;
    pos_t                  pos;
    logic [VALUE_BITS-1:0] nv;
    logic [VALUE_BITS-1:0] chg;
  } change_t;

endpackage

// File: rtl/jss_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// Self-contained; no package dependency.
module jss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

// File: rtl/jss_raster_ctrl.sv
// Row and column counters of the raster scan, with the interior and end decode.
// Depends on jss_pkg.
module jss_raster_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               advance,
  input  logic                               sweep_start,
  input  logic [jss_pkg::ROW_BITS-1:0]       grid_rows,
  input  logic [jss_pkg::COLS_CFG_BITS-1:0]  grid_cols,
  output jss_pkg::pos_t                      pos
);

  logic [jss_pkg::ROW_BITS-1:0]        row_r, row_nxt;
  logic [jss_pkg::COL_BITS-1:0]        col_r, col_nxt;
  logic [jss_pkg::ROW_BITS-1:0]        rows;
  logic [jss_pkg::COLS_CFG_BITS-1:0]   cols;
  logic [jss_pkg::ROW_BITS-1:0]        r;
  logic [jss_pkg::COL_BITS-1:0]        c;
  logic [jss_pkg::ROW_BITS:0]          r_inc;
  logic [jss_pkg::COLS_CFG_BITS:0]     c_inc, c_inc2, cols_x;
  logic                                row_last, col_last;

  always_comb begin
    rows = (grid_rows < jss_pkg::ROWS_MIN) ? jss_pkg::ROWS_MIN : grid_rows;
    if (grid_cols < jss_pkg::COLS_MIN) begin
      cols = jss_pkg::COLS_MIN;
    end else if (grid_cols > jss_pkg::COLS_MAX) begin
      cols = jss_pkg::COLS_MAX;
    end else begin
      cols = grid_cols;
    end
    cols_x = (jss_pkg::COLS_CFG_BITS+1)'(cols);

    // A sweep start puts this word at the origin.
    r = sweep_start ? '0 : row_r;
    c = sweep_start ? '0 : col_r;

    r_inc    = (jss_pkg::ROW_BITS+1)'(r) + (jss_pkg::ROW_BITS+1)'(1);
    c_inc    = (jss_pkg::COLS_CFG_BITS+1)'(c) + (jss_pkg::COLS_CFG_BITS+1)'(1);
    c_inc2   = (jss_pkg::COLS_CFG_BITS+1)'(c) + (jss_pkg::COLS_CFG_BITS+1)'(2);
    row_last = r_inc >= (jss_pkg::ROW_BITS+1)'(rows);
    col_last = c_inc >= cols_x;

    pos.row  = r;
    pos.col  = c;
    pos.emit = (r >= jss_pkg::ROW_BITS'(2)) && (r < rows) && (c != '0) && (c_inc2 <= cols_x);
    pos.done = row_last && (c_inc2 == cols_x);
    pos.clr  = sweep_start;
    pos.endg = col_last && row_last;

    if (col_last) begin
      col_nxt = '0;
      row_nxt = row_last ? '0 : r_inc[jss_pkg::ROW_BITS-1:0];
    end else begin
      col_nxt = c_inc[jss_pkg::COL_BITS-1:0];
      row_nxt = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (advance) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

// File: rtl/jss_line_window.sv
// Line store and stencil window: reads two line entries per word, forms the
// neighbor sum and writes the shifted line entry back. Depends on jss_pkg, jss_ram.
module jss_line_window (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [jss_pkg::VALUE_BITS-1:0]  cell_value,
  input  jss_pkg::pos_t                   pos,
  output logic                            s1_valid,
  output jss_pkg::stencil_t               stencil
);

  // Each line entry holds {row r-2, row r-1} for its column.
  logic [jss_pkg::LINE_BITS-1:0]  rd_a, rd_b, wr_data;
  logic [jss_pkg::COL_BITS-1:0]   addr_b;
  logic                           s1_valid_r;
  jss_pkg::pos_t                  s1_pos_r;
  logic [jss_pkg::VALUE_BITS-1:0] s1_down_r;
  logic [jss_pkg::VALUE_BITS-1:0] left_r;
  logic [jss_pkg::VALUE_BITS-1:0] up, centre, right;
  logic [jss_pkg::SUM_BITS-1:0]   sum;
  jss_pkg::stencil_t              stencil_r, stencil_nxt;

  assign addr_b = pos.col + jss_pkg::COL_BITS'(1);

  jss_ram #(
    .WIDTH (jss_pkg::LINE_BITS),
    .DEPTH (jss_pkg::LINE_MAX)
  ) u_line_ram (
    .clk     (clk),
    .we      (s1_valid_r),
    .waddr   (s1_pos_r.col),
    .wdata   (wr_data),
    .raddr_a (pos.col),
    .raddr_b (addr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_comb begin
    up      = rd_a[jss_pkg::LINE_BITS-1:jss_pkg::VALUE_BITS];
    centre  = rd_a[jss_pkg::VALUE_BITS-1:0];
    right   = rd_b[jss_pkg::VALUE_BITS-1:0];
    // The entry ages by one row: the old newer half becomes the older half.
    wr_data = {centre, s1_down_r};
    sum     = jss_pkg::SUM_BITS'(up) + jss_pkg::SUM_BITS'(s1_down_r)
            + jss_pkg::SUM_BITS'(left_r) + jss_pkg::SUM_BITS'(right);

    stencil_nxt.valid  = s1_valid_r;
    stencil_nxt.pos    = s1_pos_r;
    stencil_nxt.nv     = sum[jss_pkg::SUM_BITS-1:2];
    stencil_nxt.centre = centre;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      stencil_r.valid <= 1'b0;
    end else begin
      s1_valid_r      <= accept;
      stencil_r.valid <= stencil_nxt.valid;
    end
    if (s1_valid_r) begin
      stencil_r.pos    <= stencil_nxt.pos;
      stencil_r.nv     <= stencil_nxt.nv;
      stencil_r.centre <= stencil_nxt.centre;
    end
  end

  // The center of one column is the left neighbor of the next.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos_r  <= pos;
      s1_down_r <= cell_value;
    end
    if (s1_valid_r) begin
      left_r <= centre;
    end
  end

  assign s1_valid = s1_valid_r;
  assign stencil  = stencil_r;

endmodule

// File: rtl/jss_change_track.sv
// Absolute change per cell and the running maximum of the sweep; builds the result word.
// Depends on jss_pkg.
module jss_change_track (
  input  logic                            clk,
  input  logic                            rst_n,
  input  jss_pkg::stencil_t               stencil,
  input  logic [jss_pkg::VALUE_BITS-1:0]  threshold,
  output logic                            s3_valid,
  output logic                            push,
  output jss_pkg::out_word_t              push_word
);

  jss_pkg::change_t               chg_r;
  logic [jss_pkg::VALUE_BITS-1:0] diff;
  logic [jss_pkg::VALUE_BITS-1:0] max_r, max_nxt, base, new_max;

  assign diff = (stencil.centre >= stencil.nv) ? (stencil.centre - stencil.nv)
                                               : (stencil.nv - stencil.centre);

  always_comb begin
    base    = chg_r.pos.clr ? '0 : max_r;
    new_max = (chg_r.pos.emit && (chg_r.chg > base)) ? chg_r.chg : base;
    max_nxt = max_r;
    if (chg_r.valid) begin
      max_nxt = chg_r.pos.endg ? '0 : new_max;
    end

    push                       = chg_r.valid && chg_r.pos.emit;
    push_word.new_value        = chg_r.nv;
    push_word.out_row          = chg_r.pos.row - jss_pkg::ROW_BITS'(1);
    push_word.out_col          = chg_r.pos.col;
    push_word.cell_change      = chg_r.chg;
    push_word.sweep_max_change = new_max;
    push_word.converged        = chg_r.pos.done && (new_max < threshold);
    push_word.sweep_done       = chg_r.pos.done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chg_r.valid <= 1'b0;
      max_r       <= '0;
    end else begin
      chg_r.valid <= stencil.valid;
      max_r       <= max_nxt;
    end
    if (stencil.valid) begin
      chg_r.pos <= stencil.pos;
      chg_r.nv  <= stencil.nv;
      chg_r.chg <= diff;
    end
  end

  assign s3_valid = chg_r.valid;

endmodule

// File: rtl/jss_out_fifo.sv
// Output queue of result words in front of the result channel.
// Depends on jss_pkg.
module jss_out_fifo (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  input  jss_pkg::out_word_t                 push_word,
  input  logic                               pop_ready,
  output logic                               pop_valid,
  output jss_pkg::out_word_t                 pop_word,
  output logic [jss_pkg::FIFO_CNT_BITS-1:0]  count
);

  jss_pkg::out_word_t                  mem_r [jss_pkg::FIFO_DEPTH];
  logic [jss_pkg::FIFO_PTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [jss_pkg::FIFO_CNT_BITS-1:0]   count_r, count_nxt;
  logic                                pop;

  assign pop_valid = (count_r != '0);
  assign pop_word  = mem_r[rd_ptr_r];
  assign pop       = pop_valid && pop_ready;
  assign count     = count_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + jss_pkg::FIFO_CNT_BITS'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - jss_pkg::FIFO_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + jss_pkg::FIFO_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + jss_pkg::FIFO_PTR_BITS'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < jss_pkg::FIFO_CNT_BITS'(jss_pkg::FIFO_DEPTH)))
    else $error("result word pushed into a full output queue");

endmodule

// File: rtl/jacobi_stencil_sweep_unit.sv
// Top level of the Jacobi stencil sweep unit: configuration registers, credit
// control of the input, and the pipeline. Depends on jss_pkg and all jss_* modules.

// Takes one grid word per clock in raster order and returns, through the line,
// stencil and change registers and the output queue, one word for every interior
// cell. The rate of one word per clock is set by the line RAM, which reads two
// entries and writes one each cycle; input ready drops only when the eight-entry
// output queue, counting the three words still in the pipeline, has no room left.
// The line RAM has no reset and needs no clearing pass: a sweep from the origin
// writes every entry a result uses before reading it. Configuration writes are
// taken at every clock and must happen while no sweep words are in flight.
module jacobi_stencil_sweep_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  jss_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output jss_pkg::out_word_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [jss_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [jss_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  logic [jss_pkg::ROW_BITS-1:0]       grid_rows_r;
  logic [jss_pkg::COLS_CFG_BITS-1:0]  grid_cols_r;
  logic [jss_pkg::VALUE_BITS-1:0]     thresh_r;
  logic                               accept;
  jss_pkg::pos_t                      pos;
  logic                               s1_valid, s3_valid;
  jss_pkg::stencil_t                  stencil;
  logic                               push;
  jss_pkg::out_word_t                 push_word;
  logic [jss_pkg::FIFO_CNT_BITS-1:0]  fifo_count;
  logic [jss_pkg::OCC_BITS-1:0]       occupancy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= jss_pkg::ROWS_RESET;
      grid_cols_r <= jss_pkg::COLS_RESET;
      thresh_r    <= jss_pkg::THRESH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        jss_pkg::REG_GRID_ROWS:   grid_rows_r <= cfg_data[jss_pkg::ROW_BITS-1:0];
        jss_pkg::REG_GRID_COLS:   grid_cols_r <= cfg_data[jss_pkg::COLS_CFG_BITS-1:0];
        jss_pkg::REG_CONV_THRESH: thresh_r    <= cfg_data[jss_pkg::VALUE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Every word in the pipeline holds a credit on the output queue.
  assign occupancy = jss_pkg::OCC_BITS'(fifo_count) + jss_pkg::OCC_BITS'(s1_valid)
                   + jss_pkg::OCC_BITS'(stencil.valid) + jss_pkg::OCC_BITS'(s3_valid);
  assign in_ready  = occupancy < jss_pkg::OCC_BITS'(jss_pkg::FIFO_DEPTH);
  assign accept    = in_valid && in_ready;

  jss_raster_ctrl u_raster (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (accept),
    .sweep_start (in_data.sweep_start),
    .grid_rows   (grid_rows_r),
    .grid_cols   (grid_cols_r),
    .pos         (pos)
  );

  jss_line_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .cell_value (in_data.cell_value),
    .pos        (pos),
    .s1_valid   (s1_valid),
    .stencil    (stencil)
  );

  jss_change_track u_change (
    .clk       (clk),
    .rst_n     (rst_n),
    .stencil   (stencil),
    .threshold (thresh_r),
    .s3_valid  (s3_valid),
    .push      (push),
    .push_word (push_word)
  );

  jss_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop_ready (out_ready),
    .pop_valid (out_valid),
    .pop_word  (out_data),
    .count     (fifo_count)
  );

  a_conv_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.converged) |-> out_data.sweep_done)
    else $error("converged flag set on a word that does not end the sweep");

  a_max_covers_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.sweep_max_change >= out_data.cell_change))
    else $error("sweep maximum below the change of its own cell");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted word did not enter the line stage");

endmodule
